[rtl/vfic_pkg.sv]
// ----------------------------------------------------------------------------
// vfic_pkg
// shared constants and types of the vertex fetch index cache
// ----------------------------------------------------------------------------
package vfic_pkg;

  localparam int unsigned BatchSize  = 66;
  localparam int unsigned MaxAttribs = 16;
  localparam int unsigned SlotW      = 7;
  localparam int unsigned AttrW      = 4;
  localparam int unsigned DescW      = 117;

  // register indexes of the configuration port
  localparam logic [1:0] RegDrawMode = 2'd0;
  localparam logic [1:0] RegAttrMask = 2'd1;
  localparam logic [1:0] RegInCount  = 2'd2;

  localparam logic CmdVertex = 1'b0;
  localparam logic CmdLoad   = 1'b1;

  localparam logic KindSlot  = 1'b0;
  localparam logic KindFetch = 1'b1;

  typedef struct packed {
    logic [63:0] base;
    logic [15:0] stride;
    logic [31:0] offset;
    logic [4:0]  size;
  } attr_desc_t;

endpackage

[rtl/vertex_fetch_index_cache.sv]
// ----------------------------------------------------------------------------
// vertex_fetch_index_cache
// pre-transform vertex cache with attribute fetch request generation
// ----------------------------------------------------------------------------
// The input stream carries vertex indices (tuser low) or attribute descriptor
// loads (tuser high); tlast marks the last index of a draw. For every index
// the block looks it up in the tag store of the current batch of 66 slots.
// A hit gives one slot result. A miss gives one fetch request per enabled
// attribute (tuser high on the output) and then the slot result with tlast.
// A descriptor load gives no result. The tag search reads each stored slot
// from the tag ram and then compares it, and stops at the first hit or after
// the last stored slot. A miss then walks the attribute slots in use and,
// for each enabled attribute, reads its descriptor and passes it through the
// shared multiply and add unit. After the slot result is loaded, the next
// index is taken in the following cycle. Results leave through an output
// register, so the next item is accepted while the last result still waits; a
// stalled receiver holds the sequencer at its next result. Reset clears the
// batch, the array counter and the registers; tag and descriptor memories are
// not cleared. Configuration is written over the APB port at 0x0, 0x4 and 0x8.
// ----------------------------------------------------------------------------
module vertex_fetch_index_cache (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex_index, attr_number, attr_base, attr_stride, attr_offset, attr_size
  input  logic [159:0] s_axis_tdata,
  // command
  input  logic         s_axis_tuser,
  // last_of_draw
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cache_slot, cache_hit, fetch_attr, fetch_address, fetch_bytes, batch_end
  output logic [87:0]  m_axis_tdata,
  // kind
  output logic         m_axis_tuser,
  // last_result
  output logic         m_axis_tlast
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSrd  = 3'd1;
  localparam logic [2:0] StScmp = 3'd2;
  localparam logic [2:0] StArd  = 3'd3;
  localparam logic [2:0] StAmul = 3'd4;
  localparam logic [2:0] StAadd = 3'd5;
  localparam logic [2:0] StSlot = 3'd6;

  localparam int unsigned SW = vfic_pkg::SlotW;

  logic        draw_mode_q;
  logic [15:0] mask_q;
  logic [4:0]  in_count_q;

  logic [2:0]    state_q, state_d;
  logic [SW-1:0] fill_q, pos_q, i_q, slot_q;
  logic [31:0]   ctr_q, idx_q;
  logic          last_q, hit_q;
  logic [4:0]    j_q, n_cnt;

  logic          ov_q;
  logic [87:0]   od_q;
  logic          ou_q, ol_q;
  logic          load_ok;
  logic          ov_set;

  vfic_pkg::attr_desc_t in_desc, rd_desc;
  logic [vfic_pkg::DescW-1:0] desc_rdata;
  logic [31:0]   tag_rdata;
  logic [63:0]   addr;
  logic [15:0]   stride_eff;
  logic          bend;
  logic          in_acc;

  logic          tag_we, tag_re, desc_we, desc_re, mul_en;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_mode_q <= 1'b0;
      mask_q      <= 16'd0;
      in_count_q  <= 5'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        vfic_pkg::RegDrawMode: draw_mode_q <= pwdata[0];
        vfic_pkg::RegAttrMask: mask_q      <= pwdata[15:0];
        vfic_pkg::RegInCount:  in_count_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      vfic_pkg::RegDrawMode: prdata = {31'd0, draw_mode_q};
      vfic_pkg::RegAttrMask: prdata = {16'd0, mask_q};
      vfic_pkg::RegInCount:  prdata = {27'd0, in_count_q};
      default:               prdata = 32'd0;
    endcase
  end

  assign in_desc.base   = s_axis_tdata[99:36];
  assign in_desc.stride = s_axis_tdata[115:100];
  assign in_desc.offset = s_axis_tdata[147:116];
  assign in_desc.size   = s_axis_tdata[152:148];
  assign rd_desc        = vfic_pkg::attr_desc_t'(desc_rdata);

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load_ok       = !ov_q || m_axis_tready;
  assign ov_set        = load_ok && ((state_q == StAadd) || (state_q == StSlot));
  assign n_cnt         = (in_count_q > 5'(vfic_pkg::MaxAttribs)) ?
                         5'(vfic_pkg::MaxAttribs) : in_count_q;
  assign stride_eff    = (rd_desc.stride != 16'd0) ? rd_desc.stride :
                         {11'd0, rd_desc.size};
  assign bend          = (({1'b0, pos_q} + 8'd1) >= 8'(vfic_pkg::BatchSize)) || last_q;

  assign desc_we = in_acc && (s_axis_tuser == vfic_pkg::CmdLoad);
  assign desc_re = (state_q == StArd) && (j_q < n_cnt) && mask_q[j_q[3:0]];
  assign tag_re  = (state_q == StSrd) && (i_q < fill_q);
  assign tag_we  = (state_q == StSlot) && load_ok && !hit_q;
  assign mul_en  = (state_q == StAmul);

  vfic_ram #(.WIDTH(32), .DEPTH(vfic_pkg::BatchSize)) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(fill_q),
    .wdata_i(idx_q),
    .re_i   (tag_re),
    .raddr_i(i_q),
    .rdata_o(tag_rdata)
  );

  vfic_ram #(.WIDTH(vfic_pkg::DescW), .DEPTH(vfic_pkg::MaxAttribs)) u_desc_ram (
    .clk_i  (clk_i),
    .we_i   (desc_we),
    .waddr_i(s_axis_tdata[35:32]),
    .wdata_i(in_desc),
    .re_i   (desc_re),
    .raddr_i(j_q[3:0]),
    .rdata_o(desc_rdata)
  );

  vfic_addr_unit u_addr (
    .clk_i   (clk_i),
    .mul_en_i(mul_en),
    .stride_i(stride_eff),
    .index_i (idx_q),
    .base_i  (rd_desc.base),
    .offset_i(rd_desc.offset),
    .addr_o  (addr)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc && s_axis_tuser == vfic_pkg::CmdVertex) state_d = StSrd;
      StSrd:  state_d = (i_q < fill_q) ? StScmp : StArd;
      StScmp: state_d = (tag_rdata == idx_q) ? StSlot : StSrd;
      StArd:  begin
        if (j_q >= n_cnt) begin
          state_d = StSlot;
        end else if (mask_q[j_q[3:0]]) begin
          state_d = StAmul;
        end
      end
      StAmul: state_d = StAadd;
      StAadd: if (load_ok) state_d = StArd;
      StSlot: if (load_ok) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      pos_q   <= '0;
      ctr_q   <= 32'd0;
      i_q     <= '0;
      j_q     <= 5'd0;
      hit_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_set || (ov_q && !m_axis_tready);
      unique case (state_q)
        StIdle: begin
          i_q   <= '0;
          j_q   <= 5'd0;
          hit_q <= 1'b0;
        end
        StSrd: if (i_q >= fill_q) slot_q <= fill_q;
        StScmp: begin
          if (tag_rdata == idx_q) begin
            hit_q  <= 1'b1;
            slot_q <= i_q;
          end else begin
            i_q <= i_q + SW'(1);
          end
        end
        StArd: if (j_q < n_cnt && !mask_q[j_q[3:0]]) j_q <= j_q + 5'd1;
        StAadd: begin
          if (load_ok) begin
            j_q <= j_q + 5'd1;
          end
        end
        StSlot: begin
          if (load_ok) begin
            if (bend) begin
              fill_q <= '0;
              pos_q  <= '0;
            end else begin
              pos_q <= pos_q + SW'(1);
              if (!hit_q) fill_q <= fill_q + SW'(1);
            end
            ctr_q <= last_q ? 32'd0 : ctr_q + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // request payload and latched vertex index
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q  <= draw_mode_q ? ctr_q : s_axis_tdata[31:0];
      last_q <= s_axis_tlast;
    end
    if (state_q == StAadd && load_ok) begin
      od_q <= {6'd0, 1'b0, rd_desc.size, addr, j_q[3:0], 1'b0, slot_q};
      ou_q <= vfic_pkg::KindFetch;
      ol_q <= 1'b0;
    end else if (state_q == StSlot && load_ok) begin
      od_q <= {6'd0, bend, 5'd0, 64'd0, 4'd0, hit_q, slot_q};
      ou_q <= vfic_pkg::KindSlot;
      ol_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
  assign m_axis_tlast  = ol_q;

  a_fill_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= pos_q) else $error("fill count above batch position");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    8'(pos_q) < 8'(vfic_pkg::BatchSize)) else $error("batch position out of range");

  a_hit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSlot && hit_q) |-> slot_q < fill_q)
    else $error("hit slot beyond fill count");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StArd && j_q >= n_cnt) |=> state_q == StSlot)
    else $error("attribute loop did not close");

endmodule

[rtl/vfic_ram.sv]
// ----------------------------------------------------------------------------
// vfic_ram
// generic ram, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module vfic_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 66
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/vfic_addr_unit.sv]
// ----------------------------------------------------------------------------
// vfic_addr_unit
// shared fetch address unit: stride times index, then base plus offset
// ----------------------------------------------------------------------------
module vfic_addr_unit (
  input  logic        clk_i,
  input  logic        mul_en_i,
  input  logic [15:0] stride_i,
  input  logic [31:0] index_i,
  input  logic [63:0] base_i,
  input  logic [31:0] offset_i,
  output logic [63:0] addr_o
);

  logic [47:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= 48'(stride_i) * 48'(index_i);
    end
  end

  assign addr_o = base_i + {16'd0, prod_q} + {32'd0, offset_i};

endmodule

[sim/tb_vertex_fetch_index_cache.sv]
// ----------------------------------------------------------------------------
// tb_vertex_fetch_index_cache
// self-checking bench for the vertex fetch index cache
// ----------------------------------------------------------------------------
// A queue of vertex indices and descriptor loads feeds a stream driver. Each
// accepted request is run through a local model of the batch cache, which
// adds the expected fetch requests and slot results to a queue. A monitor
// compares every output beat field by field. Both sides idle at random but in
// the last phases; registers change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_vertex_fetch_index_cache;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        cmd;
    logic [31:0] vidx;
    logic        eod;
    logic [3:0]  anum;
    logic [63:0] abase;
    logic [15:0] astride;
    logic [31:0] aoffset;
    logic [4:0]  asize;
  } vtx_req_t;

  typedef struct {
    logic        kind;
    logic [6:0]  slot;
    logic        hit;
    logic [3:0]  attr;
    logic [63:0] addr;
    logic [4:0]  bytes;
    logic        bend;
    logic        lastr;
  } cache_out_t;

  localparam int unsigned CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [159:0] s_data = '0;
  logic s_user = 1'b0, s_last = 1'b0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [87:0] m_data;
  logic m_user, m_last;

  vertex_fetch_index_cache dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .s_axis_tuser(s_user), .s_axis_tlast(s_last),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .m_axis_tuser(m_user), .m_axis_tlast(m_last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model state
  logic [31:0] tag_mem [vfic_pkg::BatchSize];
  vfic_pkg::attr_desc_t desc_mem [vfic_pkg::MaxAttribs];
  int unsigned fill_cnt, batch_pos;
  logic [31:0] array_cnt;
  logic        mode_q;
  logic [15:0] mask_q;
  logic [4:0]  count_q;

  vtx_req_t   req_q[$];
  cache_out_t slot_fetch_q[$];
  vtx_req_t   cur_req;
  int unsigned send_idle, recv_idle;
  int unsigned err_cnt, beat_cnt, vtx_cnt, hit_cnt, cycle_cnt;

  function automatic void predict_cache_step(vtx_req_t r);
    logic [31:0] idx;
    logic [6:0]  slot;
    logic        hit;
    logic        bend;
    logic [63:0] stride;
    int unsigned n;
    cache_out_t  o;
    idx  = '0;
    slot = '0;
    hit  = 1'b0;
    if (r.cmd == vfic_pkg::CmdLoad) begin
      desc_mem[r.anum] = '{base: r.abase, stride: r.astride, offset: r.aoffset,
                           size: r.asize};
      return;
    end
    vtx_cnt++;
    idx = mode_q ? array_cnt : r.vidx;
    for (int i = 0; i < fill_cnt; i++) begin
      if (tag_mem[i] == idx) begin
        hit  = 1'b1;
        slot = 7'(i);
        break;
      end
    end
    if (!hit) begin
      slot = 7'(fill_cnt);
      n = (count_q > vfic_pkg::MaxAttribs) ? vfic_pkg::MaxAttribs : count_q;
      for (int j = 0; j < n; j++) begin
        if (mask_q[j]) begin
          stride = (desc_mem[j].stride != 0) ? 64'(desc_mem[j].stride)
                                             : 64'(desc_mem[j].size);
          o = '{kind: vfic_pkg::KindFetch, slot: slot, hit: 1'b0, attr: 4'(j),
                addr: desc_mem[j].base + stride * 64'(idx) + 64'(desc_mem[j].offset),
                bytes: desc_mem[j].size, bend: 1'b0, lastr: 1'b0};
          slot_fetch_q = {slot_fetch_q, o};
        end
      end
      if (fill_cnt < vfic_pkg::BatchSize) begin
        tag_mem[fill_cnt] = idx;
        fill_cnt++;
      end
    end else begin
      hit_cnt++;
    end
    batch_pos++;
    bend = (batch_pos >= vfic_pkg::BatchSize) || r.eod;
    o = '{kind: vfic_pkg::KindSlot, slot: slot, hit: hit, attr: '0, addr: '0,
          bytes: '0, bend: bend, lastr: 1'b1};
    slot_fetch_q = {slot_fetch_q, o};
    if (bend) begin
      fill_cnt  = 0;
      batch_pos = 0;
    end
    array_cnt = r.eod ? 32'd0 : array_cnt + 32'd1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    if (err_cnt <= 30)
      $display("mismatch %s: got %h expected %h (beat %0d)", what, got, want, beat_cnt);
  endtask

  // stream driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_ready) predict_cache_step(cur_req);
      if (!s_valid || s_ready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_req = req_q.pop_front();
          s_valid <= 1'b1;
          s_user  <= cur_req.cmd;
          s_last  <= cur_req.eod;
          s_data  <= {7'd0, cur_req.asize, cur_req.aoffset, cur_req.astride,
                      cur_req.abase, cur_req.anum, cur_req.vidx};
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    cache_out_t w;
    if (rst_ni) begin
      m_ready <= ($urandom_range(99) >= recv_idle);
      if (m_valid && m_ready) begin
        beat_cnt++;
        if (slot_fetch_q.size() == 0) begin
          report_mismatch("unexpected beat", m_data[63:0], 64'd0);
        end else begin
          w = slot_fetch_q.pop_front();
          if (m_user != w.kind) report_mismatch("kind", 64'(m_user), 64'(w.kind));
          if (m_data[6:0] != w.slot)
            report_mismatch("cache_slot", 64'(m_data[6:0]), 64'(w.slot));
          if (m_data[7] != w.hit)
            report_mismatch("cache_hit", 64'(m_data[7]), 64'(w.hit));
          if (m_data[11:8] != w.attr)
            report_mismatch("fetch_attr", 64'(m_data[11:8]), 64'(w.attr));
          if (m_data[75:12] != w.addr)
            report_mismatch("fetch_address", m_data[75:12], w.addr);
          if (m_data[80:76] != w.bytes)
            report_mismatch("fetch_bytes", 64'(m_data[80:76]), 64'(w.bytes));
          if (m_data[81] != w.bend)
            report_mismatch("batch_end", 64'(m_data[81]), 64'(w.bend));
          if (m_last != w.lastr)
            report_mismatch("last_result", 64'(m_last), 64'(w.lastr));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout with %0d results outstanding", slot_fetch_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] regidx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regidx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (regidx)
      vfic_pkg::RegDrawMode: mode_q  = val[0];
      vfic_pkg::RegAttrMask: mask_q  = val[15:0];
      vfic_pkg::RegInCount:  count_q = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic mode, logic [15:0] mask, logic [4:0] cnt);
    reg_write(vfic_pkg::RegDrawMode, {31'd0, mode});
    reg_write(vfic_pkg::RegAttrMask, {16'd0, mask});
    reg_write(vfic_pkg::RegInCount, {27'd0, cnt});
  endtask

  // let every queued request drain, then allow the block to finish a load
  task automatic wait_drained();
    do @(negedge clk_i);
    while (req_q.size() != 0 || s_valid || slot_fetch_q.size() != 0);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic void push_vertex(logic [31:0] idx, logic eod);
    vtx_req_t r;
    r = '{cmd: vfic_pkg::CmdVertex, vidx: idx, eod: eod, anum: 4'($urandom),
          abase: {$urandom, $urandom}, astride: 16'($urandom), aoffset: $urandom,
          asize: 5'($urandom)};
    req_q = {req_q, r};
  endfunction

  function automatic void push_load(logic [3:0] num, logic [63:0] base,
                                    logic [15:0] stride, logic [31:0] off,
                                    logic [4:0] sz);
    vtx_req_t r;
    r = '{cmd: vfic_pkg::CmdLoad, vidx: $urandom, eod: 1'($urandom), anum: num,
          abase: base, astride: stride, aoffset: off, asize: sz};
    req_q = {req_q, r};
  endfunction

  function automatic void push_random(int unsigned count);
    logic [15:0] st;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 8) begin
        st = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
        push_load(4'($urandom), {$urandom, $urandom}, st, $urandom,
                  5'($urandom_range(31)));
      end else if ($urandom_range(99) < 70) begin
        // small index pool so that repeats hit within the batch
        push_vertex($urandom_range(11), $urandom_range(99) < 4);
      end else begin
        push_vertex($urandom, $urandom_range(99) < 4);
      end
    end
  endfunction

  initial begin
    fill_cnt  = 0;
    batch_pos = 0;
    array_cnt = '0;
    mode_q    = 1'b0;
    mask_q    = '0;
    count_q   = 5'd1;
    send_idle = 31;
    recv_idle = 56;
    err_cnt   = 0;
    beat_cnt  = 0;
    vtx_cnt   = 0;
    hit_cnt   = 0;
    cycle_cnt = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: descriptor extremes, then indices with hits and draw end
    set_regs(1'b0, 16'hFFFF, 5'd16);
    push_load(4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 32'hFFFF_FFFF, 5'd16);
    push_load(4'd1, 64'd0, 16'hFFFF, 32'd0, 5'd1);
    push_load(4'd2, 64'h8000_0000_0000_0000, 16'd0, 32'h1234_5678, 5'd31);
    push_load(4'd3, 64'd0, 16'd0, 32'd0, 5'd0);
    for (int j = 4; j < vfic_pkg::MaxAttribs; j++)
      push_load(4'(j), {$urandom, $urandom}, 16'($urandom), $urandom, 5'($urandom));
    push_vertex(32'd0, 1'b0);
    push_vertex(32'hFFFF_FFFF, 1'b0);
    push_vertex(32'd0, 1'b0);
    push_vertex(32'hFFFF_FFFF, 1'b0);
    push_vertex(32'd5, 1'b1);
    push_vertex(32'd5, 1'b0);
    wait_drained();

    // full batch without draw end, then random traffic
    set_regs(1'b0, 16'($urandom), 5'($urandom_range(1, 16)));
    for (int k = 0; k < 70; k++) push_vertex(32'(k % 68), 1'b0);
    push_random(60);
    wait_drained();

    send_idle = 56;
    recv_idle = 31;
    set_regs(1'b1, 16'($urandom), 5'd31);
    push_random(50);
    push_vertex(32'd0, 1'b1);
    wait_drained();
    set_regs(1'b0, 16'h0000, 5'd0);
    push_random(40);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    set_regs(1'b1, 16'hFFFF, 5'd1);
    push_random(40);
    wait_drained();
    set_regs(1'b0, 16'($urandom), 5'($urandom_range(1, 16)));
    push_random(60);
    wait_drained();

    $display("%0d vertices (%0d cache hits), %0d output beats checked", vtx_cnt,
             hit_cnt, beat_cnt);
    $display("covered indexed and array draws, batch ends, masks and counts 0..31");
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[vertex_fetch_index_cache.f]
rtl/vfic_pkg.sv
rtl/vfic_ram.sv
rtl/vfic_addr_unit.sv
rtl/vertex_fetch_index_cache.sv
sim/tb_vertex_fetch_index_cache.sv
